>>> rtl/core/point_in_yawed_volume_test_core_defines.svh
// assertion macros for the point in yawed volume test core
`ifndef POINT_IN_YAWED_VOLUME_TEST_CORE_DEFINES_SVH
`define POINT_IN_YAWED_VOLUME_TEST_CORE_DEFINES_SVH

// condition implies consequence in the same cycle
`define PIYV_ASSERT_NOW(lbl, cond, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (cons)) \
        else $error("assertion failed");

// condition implies consequence in the next cycle
`define PIYV_ASSERT_NEXT(lbl, cond, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/piyv_pkg.sv
// shared types, constants and trig table for the point in yawed volume test core
package piyv_pkg;

    localparam int TRIG_TABLE_BITS = 10;
    localparam int QN              = 2 ** (TRIG_TABLE_BITS - 2);
    localparam int ANG_SHIFT       = 16 - TRIG_TABLE_BITS;
    localparam int SIN_A           = 51436;
    localparam int SIN_B           = 20953;
    localparam int SIN_C           = 2285;

    localparam int POS_W     = 32;
    localparam int ROT_IN_W  = 36;
    localparam int PROD_W    = ROT_IN_W + 16;
    localparam int ROT_OUT_W = PROD_W + 2 - 15;
    localparam int DY_W      = 34;
    localparam int STAGES    = 9;
    localparam int IN_W      = 208;

    localparam logic [1:0] SHAPE_BOX      = 2'd0;
    localparam logic [1:0] SHAPE_SPHERE   = 2'd1;
    localparam logic [1:0] SHAPE_CAPSULE  = 2'd2;
    localparam logic [1:0] SHAPE_CYLINDER = 2'd3;

    localparam logic [2:0] REG_SHAPE    = 3'd0;
    localparam logic [2:0] REG_OFFSET_X = 3'd1;
    localparam logic [2:0] REG_OFFSET_Y = 3'd2;
    localparam logic [2:0] REG_OFFSET_Z = 3'd3;
    localparam logic [2:0] REG_YAW      = 3'd4;
    localparam logic [2:0] REG_EXTENT_X = 3'd5;
    localparam logic [2:0] REG_EXTENT_Y = 3'd6;
    localparam logic [2:0] REG_EXTENT_Z = 3'd7;

    typedef logic [14:0] sin_tab_t [0:QN];

    typedef struct packed {
        logic        [1:0]  shape;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic signed [31:0] offset_z;
        logic        [15:0] yaw;
        logic        [30:0] extent_x;
        logic        [30:0] extent_y;
        logic        [30:0] extent_z;
    } cfg_t;

    typedef struct packed {
        logic signed [ROT_OUT_W-1:0] lx;
        logic signed [DY_W-1:0]      ly;
        logic signed [ROT_OUT_W-1:0] lz;
    } loc_t;

    typedef struct packed {
        logic signed [15:0] c;
        logic signed [15:0] s;
    } trig_t;

    function automatic sin_tab_t build_sin_tab();
        sin_tab_t   tab;
        longint     z;
        longint     z2;
        longint     t;
        for (int i = 0; i <= QN; i++) begin
            z  = longint'(i) << ANG_SHIFT;
            z2 = (z * z) >> 14;
            t  = (SIN_C * z2) >> 14;
            t  = SIN_B - t;
            t  = (t * z2) >> 14;
            t  = SIN_A - t;
            t  = (t * z) >> 14;
            if (t > 32767) t = 32767;
            tab[i] = t[14:0];
        end
        return tab;
    endfunction

    localparam sin_tab_t SIN_TAB = build_sin_tab();

    function automatic logic signed [15:0] sin_q15(input logic [15:0] ang);
        logic [TRIG_TABLE_BITS-1:0] a;
        logic [TRIG_TABLE_BITS-2:0] idx;
        logic [15:0]                mag;
        a   = ang[15:ANG_SHIFT];
        idx = a[TRIG_TABLE_BITS-2] ? (TRIG_TABLE_BITS-1)'(QN) -
              {1'b0, a[TRIG_TABLE_BITS-3:0]} : {1'b0, a[TRIG_TABLE_BITS-3:0]};
        mag = {1'b0, SIN_TAB[idx]};
        return a[TRIG_TABLE_BITS-1] ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic trig_t trig_of(input logic [15:0] ang);
        trig_t r;
        r.c = sin_q15(ang + 16'd16384);
        r.s = sin_q15(ang);
        return r;
    endfunction

endpackage

>>> rtl/core/point_in_yawed_volume_test_core.sv
// top level of the point in yawed volume test core
// channel   dir  handshake           payload
// s_axis    in   s_tvalid/s_tready   attacker position, yaw, query point
// m_axis    out  m_tvalid/m_tready   inside_res
// cfg       in   cfg_valid/cfg_ready register index and data
// nine register stages, one beat accepted per cycle while the output is not stalled
// the stages hold the trig lookups, two rotations (multiply, round), the differences and the square/sum test
// a stalled output freezes every stage; nothing is dropped or repeated
// synchronous active low reset clears valids and loads register defaults
`include "point_in_yawed_volume_test_core_defines.svh"
module point_in_yawed_volume_test_core
    import piyv_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    // attacker_x, attacker_y, attacker_z, attacker_yaw, point_x, point_y, point_z
    input  logic [IN_W-1:0] s_tdata,
    output logic            m_tvalid,
    input  logic            m_tready,
    // inside_res, zero fill
    output logic [7:0]      m_tdata,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [2:0]      cfg_index,
    input  logic [31:0]     cfg_data
);

    cfg_t              cfg_reg;
    logic [STAGES-1:0] vld_reg, vld_next;
    logic              adv, hit;
    loc_t              loc;

    assign adv       = !vld_reg[STAGES-1] || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.shape    <= SHAPE_BOX;
            cfg_reg.offset_x <= '0;
            cfg_reg.offset_y <= '0;
            cfg_reg.offset_z <= '0;
            cfg_reg.yaw      <= '0;
            cfg_reg.extent_x <= 31'd65536;
            cfg_reg.extent_y <= 31'd65536;
            cfg_reg.extent_z <= 31'd65536;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SHAPE:    cfg_reg.shape    <= cfg_data[1:0];
                REG_OFFSET_X: cfg_reg.offset_x <= cfg_data;
                REG_OFFSET_Y: cfg_reg.offset_y <= cfg_data;
                REG_OFFSET_Z: cfg_reg.offset_z <= cfg_data;
                REG_YAW:      cfg_reg.yaw      <= cfg_data[15:0];
                REG_EXTENT_X: cfg_reg.extent_x <= cfg_data[30:0];
                REG_EXTENT_Y: cfg_reg.extent_y <= cfg_data[30:0];
                REG_EXTENT_Z: cfg_reg.extent_z <= cfg_data[30:0];
                default:      ;
            endcase
        end
    end

    assign vld_next = {vld_reg[STAGES-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    piyv_place u_place (
        .aclk   (aclk),
        .en     (adv),
        .cfg    (cfg_reg),
        .ax_in  (s_tdata[31:0]),
        .ay_in  (s_tdata[63:32]),
        .az_in  (s_tdata[95:64]),
        .yaw_in (s_tdata[111:96]),
        .px_in  (s_tdata[143:112]),
        .py_in  (s_tdata[175:144]),
        .pz_in  (s_tdata[207:176]),
        .loc    (loc)
    );

    piyv_shape u_shape (
        .aclk (aclk),
        .en   (adv),
        .cfg  (cfg_reg),
        .loc  (loc),
        .hit  (hit)
    );

    assign m_tvalid = vld_reg[STAGES-1];
    assign m_tdata  = {7'd0, hit};

    `PIYV_ASSERT_NEXT(a_stall_freezes, !adv, $stable(vld_reg))
    `PIYV_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, vld_reg[0])
    `PIYV_ASSERT_NOW(a_out_fill_zero, m_tvalid, m_tdata[7:1] == 7'd0)

endmodule

>>> rtl/core/piyv_rotate.sv
// two stage yaw rotation with round to nearest
module piyv_rotate
    import piyv_pkg::*;
(
    input  logic                        aclk,
    input  logic                        en,
    input  logic signed [ROT_IN_W-1:0]  x_in,
    input  logic signed [ROT_IN_W-1:0]  z_in,
    input  trig_t                       trig,
    output logic signed [ROT_OUT_W-1:0] x_out,
    output logic signed [ROT_OUT_W-1:0] z_out
);

    logic signed [PROD_W-1:0]    xc_reg, zs_reg, zc_reg, xs_reg;
    logic signed [PROD_W+1:0]    sum_x, sum_z;
    logic signed [ROT_OUT_W-1:0] x_reg, z_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            xc_reg <= x_in * trig.c;
            zs_reg <= z_in * trig.s;
            zc_reg <= z_in * trig.c;
            xs_reg <= x_in * trig.s;
        end
    end

    always_comb begin
        sum_x = (PROD_W+2)'(xc_reg) + (PROD_W+2)'(zs_reg) + (PROD_W+2)'(16384);
        sum_z = (PROD_W+2)'(zc_reg) - (PROD_W+2)'(xs_reg) + (PROD_W+2)'(16384);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= sum_x[PROD_W+1:15];
            z_reg <= sum_z[PROD_W+1:15];
        end
    end

    assign x_out = x_reg;
    assign z_out = z_reg;

endmodule

>>> rtl/core/piyv_place.sv
// volume placement: offset rotation, relative point and back rotation
module piyv_place
    import piyv_pkg::*;
(
    input  logic               aclk,
    input  logic               en,
    input  cfg_t               cfg,
    input  logic signed [31:0] ax_in,
    input  logic signed [31:0] ay_in,
    input  logic signed [31:0] az_in,
    input  logic        [15:0] yaw_in,
    input  logic signed [31:0] px_in,
    input  logic signed [31:0] py_in,
    input  logic signed [31:0] pz_in,
    output loc_t               loc
);

    trig_t              trig1_reg, trig4_reg;
    logic signed [31:0] ax1_reg, ay1_reg, az1_reg, px1_reg, py1_reg, pz1_reg;
    logic signed [31:0] ax2_reg, az2_reg, px2_reg, pz2_reg;
    logic signed [31:0] ax3_reg, az3_reg, px3_reg, pz3_reg;
    logic        [15:0] yaw1_reg, yaw2_reg, yaw3_reg;
    logic signed [DY_W-1:0] dy2_reg, dy3_reg, dy4_reg, dy5_reg, dy6_reg;
    logic signed [ROT_IN_W-1:0]  dx4_reg, dz4_reg, off_x, off_z;
    logic signed [ROT_OUT_W-1:0] rx, rz, lx, lz;
    logic signed [ROT_OUT_W:0]   dx_next, dz_next;
    logic        [15:0]          back_ang;

    assign off_x = ROT_IN_W'(cfg.offset_x);
    assign off_z = ROT_IN_W'(cfg.offset_z);

    always_ff @(posedge aclk) begin
        if (en) begin
            trig1_reg <= trig_of(yaw_in);
            ax1_reg <= ax_in; ay1_reg <= ay_in; az1_reg <= az_in;
            px1_reg <= px_in; py1_reg <= py_in; pz1_reg <= pz_in;
            yaw1_reg <= yaw_in;
        end
    end

    piyv_rotate u_rot_off (
        .aclk  (aclk),
        .en    (en),
        .x_in  (off_x),
        .z_in  (off_z),
        .trig  (trig1_reg),
        .x_out (rx),
        .z_out (rz)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            ax2_reg <= ax1_reg; az2_reg <= az1_reg;
            px2_reg <= px1_reg; pz2_reg <= pz1_reg; yaw2_reg <= yaw1_reg;
            dy2_reg <= DY_W'(py1_reg) - (DY_W'(ay1_reg) + DY_W'(cfg.offset_y));
            ax3_reg <= ax2_reg; az3_reg <= az2_reg;
            px3_reg <= px2_reg; pz3_reg <= pz2_reg; yaw3_reg <= yaw2_reg;
            dy3_reg <= dy2_reg;
        end
    end

    always_comb begin
        dx_next  = (ROT_OUT_W+1)'(px3_reg) - ((ROT_OUT_W+1)'(ax3_reg) + (ROT_OUT_W+1)'(rx));
        dz_next  = (ROT_OUT_W+1)'(pz3_reg) - ((ROT_OUT_W+1)'(az3_reg) + (ROT_OUT_W+1)'(rz));
        back_ang = 16'd0 - (yaw3_reg + cfg.yaw);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx4_reg   <= dx_next[ROT_IN_W-1:0];
            dz4_reg   <= dz_next[ROT_IN_W-1:0];
            trig4_reg <= trig_of(back_ang);
            dy4_reg   <= dy3_reg;
            dy5_reg   <= dy4_reg;
            dy6_reg   <= dy5_reg;
        end
    end

    piyv_rotate u_rot_back (
        .aclk  (aclk),
        .en    (en),
        .x_in  (dx4_reg),
        .z_in  (dz4_reg),
        .trig  (trig4_reg),
        .x_out (lx),
        .z_out (lz)
    );

    assign loc.lx = lx;
    assign loc.ly = dy6_reg;
    assign loc.lz = lz;

endmodule

>>> rtl/core/piyv_shape.sv
// shape inclusion test over three stages
module piyv_shape
    import piyv_pkg::*;
(
    input  logic aclk,
    input  logic en,
    input  cfg_t cfg,
    input  loc_t loc,
    output logic hit
);

    logic [ROT_OUT_W-1:0] abs_x, abs_z;
    logic [DY_W-1:0]      abs_y;
    logic [ROT_OUT_W:0]   x2, z2;
    logic [DY_W:0]        y2, b_cap, b_sel;
    logic [31:0]          r2, seg;
    logic signed [32:0]   seg_s;
    logic                 far;

    logic [31:0] a7_reg, b7_reg, c7_reg, r7_reg;
    logic        far7_reg, box7_reg, cyly7_reg;
    logic [1:0]  shape7_reg, shape8_reg;
    logic [63:0] aa8_reg, bb8_reg, cc8_reg, rr8_reg;
    logic        far8_reg, box8_reg, cyly8_reg;
    logic [65:0] sum;
    logic        round_in, hit_next, hit_reg;

    always_comb begin
        abs_x = loc.lx[ROT_OUT_W-1] ? ROT_OUT_W'(-loc.lx) : ROT_OUT_W'(loc.lx);
        abs_z = loc.lz[ROT_OUT_W-1] ? ROT_OUT_W'(-loc.lz) : ROT_OUT_W'(loc.lz);
        abs_y = loc.ly[DY_W-1] ? DY_W'(-loc.ly) : DY_W'(loc.ly);
        x2 = {abs_x, 1'b0};
        z2 = {abs_z, 1'b0};
        y2 = {abs_y, 1'b0};
        r2 = {cfg.extent_x, 1'b0};
        seg_s = $signed({2'b00, cfg.extent_y}) - $signed({1'b0, r2});
        seg = seg_s[32] ? 32'd0 : seg_s[31:0];
        b_cap = (y2 > (DY_W+1)'(seg)) ? y2 - (DY_W+1)'(seg) : '0;
        case (cfg.shape)
            SHAPE_SPHERE:  b_sel = y2;
            SHAPE_CAPSULE: b_sel = b_cap;
            default:       b_sel = '0;
        endcase
        far = (x2 > (ROT_OUT_W+1)'(r2)) || (z2 > (ROT_OUT_W+1)'(r2)) ||
              (b_sel > (DY_W+1)'(r2));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a7_reg     <= x2[31:0];
            b7_reg     <= b_sel[31:0];
            c7_reg     <= z2[31:0];
            r7_reg     <= r2;
            far7_reg   <= far;
            cyly7_reg  <= y2 <= (DY_W+1)'(cfg.extent_y);
            box7_reg   <= (x2 <= (ROT_OUT_W+1)'(cfg.extent_x)) &&
                          (y2 <= (DY_W+1)'(cfg.extent_y)) &&
                          (z2 <= (ROT_OUT_W+1)'(cfg.extent_z));
            shape7_reg <= cfg.shape;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            aa8_reg    <= 64'(a7_reg) * 64'(a7_reg);
            bb8_reg    <= 64'(b7_reg) * 64'(b7_reg);
            cc8_reg    <= 64'(c7_reg) * 64'(c7_reg);
            rr8_reg    <= 64'(r7_reg) * 64'(r7_reg);
            far8_reg   <= far7_reg;
            box8_reg   <= box7_reg;
            cyly8_reg  <= cyly7_reg;
            shape8_reg <= shape7_reg;
        end
    end

    always_comb begin
        sum = 66'(aa8_reg) + 66'(bb8_reg) + 66'(cc8_reg);
        round_in = !far8_reg && (sum <= 66'(rr8_reg));
        case (shape8_reg)
            SHAPE_SPHERE:   hit_next = round_in;
            SHAPE_CAPSULE:  hit_next = round_in;
            SHAPE_CYLINDER: hit_next = round_in && cyly8_reg;
            default:        hit_next = box8_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hit_reg <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule
